FILE: src/rrrt_pkg.sv
// Shared types and constants for the rect_range_reduce_tree block.
// Used by the controller, the datapath and the top level. No dependencies.
package rrrt_pkg;

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REDUCE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_SUM = 3'd0,
      MODE_MIN = 3'd1,
      MODE_MAX = 3'd2,
      MODE_XOR = 3'd3,
      MODE_AND = 3'd4,
      MODE_OR  = 3'd5
   } mode_type;

   localparam logic CSR_MODE     = 1'b0;
   localparam logic CSR_IDENTITY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SET_LEAF,
      ST_SET_RD_A,
      ST_SET_RD_B,
      ST_SET_WR,
      ST_GET_RD,
      ST_GET_WAIT,
      ST_Q_NEXT,
      ST_Q_RD,
      ST_Q_WAIT,
      ST_Q_ACC,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;       // latch request fields
      logic clr_step;    // write identity at the clear pointer and advance
      logic set_leaf;    // write new value into leaf, init walk
      logic rd_a;        // read first child
      logic rd_b;        // read second child
      logic set_wr;      // write combined node and advance walk
      logic get_rd;      // read leaf for get
      logic get_cap;     // capture get result
      logic q_next;      // pick next query term
      logic q_rd;        // read selected term
      logic q_acc;       // accumulate term
      logic out_load;    // load result register
   } cmd_bus_type;

   // Status from the datapath back to the controller
   typedef struct packed {
      logic clr_done;
      logic set_valid;   // set target inside grid
      logic set_done;    // walk finished
      logic q_have;      // a term was selected
      logic q_done;      // query finished
   } sts_bus_type;

endpackage

FILE: src/rrrt_ctrl.sv
// Controller state machine for rect_range_reduce_tree.
// Depends on rrrt_pkg; drives the datapath by command bus only.
module rrrt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  rrrt_pkg::cmd_type     req_command,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrrt_pkg::cmd_bus_type cmd,
   input  rrrt_pkg::sts_bus_type sts
);

   rrrt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                out_free;

   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   // Take a new transaction whenever idle; a waiting result sits in the output register
   assign req_stall = (state_ff != rrrt_pkg::ST_IDLE);
   // Output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrrt_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  rrrt_pkg::CMD_SET:    state_in = rrrt_pkg::ST_SET_LEAF;
                  rrrt_pkg::CMD_GET:    state_in = rrrt_pkg::ST_GET_RD;
                  rrrt_pkg::CMD_REDUCE: state_in = rrrt_pkg::ST_Q_NEXT;
                  default:              state_in = rrrt_pkg::ST_CLEAR;
               endcase
            end
         end
         rrrt_pkg::ST_CLEAR:    if (sts.clr_done) state_in = rrrt_pkg::ST_IDLE;
         rrrt_pkg::ST_SET_LEAF: begin
            if (!sts.set_valid || sts.set_done) state_in = rrrt_pkg::ST_IDLE;
            else state_in = rrrt_pkg::ST_SET_RD_A;
         end
         rrrt_pkg::ST_SET_RD_A: state_in = rrrt_pkg::ST_SET_RD_B;
         rrrt_pkg::ST_SET_RD_B: state_in = rrrt_pkg::ST_SET_WR;
         rrrt_pkg::ST_SET_WR: begin
            if (sts.set_done) state_in = rrrt_pkg::ST_IDLE;
            else state_in = rrrt_pkg::ST_SET_RD_A;
         end
         rrrt_pkg::ST_GET_RD:   state_in = rrrt_pkg::ST_GET_WAIT;
         rrrt_pkg::ST_GET_WAIT: state_in = rrrt_pkg::ST_OUT;
         rrrt_pkg::ST_Q_NEXT: begin
            if (sts.q_done) state_in = rrrt_pkg::ST_OUT;
            else if (sts.q_have) state_in = rrrt_pkg::ST_Q_RD;
         end
         rrrt_pkg::ST_Q_RD:   state_in = rrrt_pkg::ST_Q_WAIT;
         rrrt_pkg::ST_Q_WAIT: state_in = rrrt_pkg::ST_Q_ACC;
         rrrt_pkg::ST_Q_ACC:  state_in = rrrt_pkg::ST_Q_NEXT;
         rrrt_pkg::ST_OUT:    if (out_free) state_in = rrrt_pkg::ST_IDLE;
         default:             state_in = rrrt_pkg::ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd = '0;
      cmd.start = accept;
      case (state_ff)
         rrrt_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
         rrrt_pkg::ST_SET_LEAF: cmd.set_leaf = sts.set_valid;
         rrrt_pkg::ST_SET_RD_A: cmd.rd_a     = 1'b1;
         rrrt_pkg::ST_SET_RD_B: cmd.rd_b     = 1'b1;
         rrrt_pkg::ST_SET_WR:   cmd.set_wr   = 1'b1;
         rrrt_pkg::ST_GET_RD:   cmd.get_rd   = 1'b1;
         rrrt_pkg::ST_GET_WAIT: cmd.get_cap  = 1'b1;
         rrrt_pkg::ST_Q_NEXT:   cmd.q_next   = 1'b1;
         rrrt_pkg::ST_Q_RD:     cmd.q_rd     = 1'b1;
         rrrt_pkg::ST_Q_ACC:    cmd.q_acc    = 1'b1;
         rrrt_pkg::ST_OUT:      cmd.out_load = out_free;
         default: ;
      endcase
   end

   // Result valid: raise on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrrt_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/rrrt_dp.sv
// Datapath for rect_range_reduce_tree: node memory, set walk, query walk.
// Depends on rrrt_pkg; sequenced by rrrt_ctrl over the command bus.
module rrrt_dp #(
   parameter int ROWS        = 16,
   parameter int COLS        = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             mode,
   input  logic [VALUE_WIDTH-1:0] ident,
   input  logic [3:0]             req_row,
   input  logic [3:0]             req_col,
   input  logic [VALUE_WIDTH-1:0] req_val,
   input  logic [4:0]             req_row_start,
   input  logic [4:0]             req_row_end,
   input  logic [4:0]             req_col_start,
   input  logic [4:0]             req_col_end,
   input  rrrt_pkg::cmd_bus_type  cmd,
   output rrrt_pkg::sts_bus_type  sts,
   output logic [31:0]            result
);

   localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CB    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int PR    = 1 << RB;
   localparam int PC    = 1 << CB;
   localparam int NR    = RB + 1;          // node index width, rows
   localparam int NC    = CB + 1;
   localparam int AW    = NR + NC;
   localparam int DEPTH = 1 << AW;
   localparam int EW    = 9;               // bound width, holds up to 511

   // Node memory, address {row node, col node}, indices 1-based heap
   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_ff;
   logic [AW-1:0]          raddr, waddr;
   logic [VALUE_WIDTH-1:0] wdata;
   logic                   we;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // Combine function
   function automatic logic [VALUE_WIDTH-1:0] comb_f(
      input logic [2:0] m, input logic [VALUE_WIDTH-1:0] a, input logic [VALUE_WIDTH-1:0] b);
      logic less;
      less = $signed(a) < $signed(b);
      case (m)
         rrrt_pkg::MODE_MIN: comb_f = less ? a : b;
         rrrt_pkg::MODE_MAX: comb_f = less ? b : a;
         rrrt_pkg::MODE_XOR: comb_f = a ^ b;
         rrrt_pkg::MODE_AND: comb_f = a & b;
         rrrt_pkg::MODE_OR:  comb_f = a | b;
         default:            comb_f = a + b;
      endcase
   endfunction

   // Clear sweep
   logic [AW:0] clr_ff;
   assign sts.clr_done = clr_ff[AW];
   always_ff @(posedge clock) begin
      if (reset || cmd.start) clr_ff <= '0;
      else if (cmd.clr_step && !clr_ff[AW]) clr_ff <= clr_ff + 1'b1;
   end

   // Request capture and clamping
   logic [NR-1:0] leaf_r_ff, ri_ff;    // set walk row node
   logic [NC-1:0] leaf_c_ff, ci_ff;    // set walk col node
   logic          valid_ff;
   logic [VALUE_WIDTH-1:0] val_ff, a_ff, acc_ff;
   logic [NR:0]   hl_ff, hr_ff;
   logic [NC:0]   wl_ff, wr_ff, cl_ff, cr_ff;
   logic          inrow_ff;             // inner column walk active
   logic [NR-1:0] cur_row_ff;
   logic [AW-1:0] term_ff;
   logic [EW-1:0] rs_c, re_c, cs_c, ce_c;

   assign rs_c = ({4'd0, req_row_start} > EW'(ROWS)) ? EW'(ROWS) : {4'd0, req_row_start};
   assign re_c = ({4'd0, req_row_end}   > EW'(ROWS)) ? EW'(ROWS) : {4'd0, req_row_end};
   assign cs_c = ({4'd0, req_col_start} > EW'(COLS)) ? EW'(COLS) : {4'd0, req_col_start};
   assign ce_c = ({4'd0, req_col_end}   > EW'(COLS)) ? EW'(COLS) : {4'd0, req_col_end};

   // Set walk: columns first within a row node, then climb the row
   logic set_last_col, set_last;
   assign set_last_col = (ci_ff == NC'(1));
   assign set_last     = set_last_col && (ri_ff == NR'(1));
   assign sts.set_valid = valid_ff;
   assign sts.set_done  = set_last;

   // Leaf row keeps combining its column children; upper rows combine row children
   logic leaf_row;
   assign leaf_row = (ri_ff == leaf_r_ff);

   // Query term selection (half-open on 1-based heap: [l, r))
   logic          sel_have, sel_done;
   logic [AW-1:0] sel_addr;
   logic          pick_l_row, pick_r_row, pick_l_col, pick_r_col;
   assign pick_l_col = inrow_ff && (cl_ff < cr_ff) && cl_ff[0];
   assign pick_r_col = inrow_ff && (cl_ff < cr_ff) && cr_ff[0];
   assign pick_l_row = !inrow_ff && (hl_ff < hr_ff) && hl_ff[0];
   assign pick_r_row = !inrow_ff && (hl_ff < hr_ff) && hr_ff[0];
   assign sts.q_have = sel_have;
   assign sts.q_done = sel_done;

   always_comb begin
      sel_have = 1'b0;
      sel_done = 1'b0;
      sel_addr = {cur_row_ff, cl_ff[NC-1:0]};
      if (inrow_ff) begin
         if (pick_l_col) begin
            sel_have = 1'b1;
            sel_addr = {cur_row_ff, cl_ff[NC-1:0]};
         end else if (pick_r_col) begin
            sel_have = 1'b1;
            sel_addr = {cur_row_ff, NC'(cr_ff - 1'b1)};
         end
      end else if (!(hl_ff < hr_ff)) begin
         sel_done = 1'b1;
      end
   end

   // Memory port muxing
   always_comb begin
      we    = 1'b0;
      waddr = {ri_ff, ci_ff};
      wdata = comb_f(mode, a_ff, rd_ff);
      raddr = term_ff;
      if (cmd.clr_step && !clr_ff[AW]) begin
         we    = 1'b1;
         waddr = clr_ff[AW-1:0];
         wdata = ident;
      end else if (cmd.set_leaf) begin
         we    = 1'b1;
         waddr = {leaf_r_ff, leaf_c_ff};
         wdata = val_ff;
      end else if (cmd.set_wr) begin
         we = 1'b1;
      end
      if (cmd.rd_a) begin
         raddr = leaf_row ? {ri_ff, NC'({ci_ff, 1'b0})}
                          : {NR'({ri_ff, 1'b0}), ci_ff};
      end else if (cmd.rd_b) begin
         raddr = leaf_row ? {ri_ff, NC'({ci_ff, 1'b1})}
                          : {NR'({ri_ff, 1'b1}), ci_ff};
      end else if (cmd.get_rd) begin
         raddr = {leaf_r_ff, leaf_c_ff};
      end
   end

   // Walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         valid_ff  <= (32'(req_row) < ROWS) && (32'(req_col) < COLS);
         leaf_r_ff <= NR'(PR) + NR'(req_row);
         leaf_c_ff <= NC'(PC) + NC'(req_col);
         ri_ff     <= NR'(PR) + NR'(req_row);
         ci_ff     <= NC'(PC) + NC'(req_col);
         val_ff    <= req_val;
         acc_ff    <= ident;
         hl_ff     <= (NR+1)'(PR) + (NR+1)'(rs_c);
         hr_ff     <= (NR+1)'(PR) + (NR+1)'(re_c);
         wl_ff     <= (NC+1)'(PC) + (NC+1)'(cs_c);
         wr_ff     <= (NC+1)'(PC) + (NC+1)'(ce_c);
         inrow_ff  <= 1'b0;
      end
      // after leaf write, climb to parent column in leaf row
      if (cmd.set_leaf) begin
         if (ci_ff == NC'(1)) begin
            ri_ff <= ri_ff >> 1;
            ci_ff <= leaf_c_ff;
         end else begin
            ci_ff <= ci_ff >> 1;
         end
      end
      if (cmd.rd_b) a_ff <= rd_ff;
      if (cmd.set_wr) begin
         if (set_last_col) begin
            ri_ff <= ri_ff >> 1;
            ci_ff <= leaf_c_ff;
         end else begin
            ci_ff <= ci_ff >> 1;
         end
      end
      if (cmd.get_cap) acc_ff <= valid_ff ? rd_ff : ident;
      // Query: row loop picks row nodes, then runs column loop
      if (cmd.q_next) begin
         if (inrow_ff) begin
            if (pick_l_col) begin
               term_ff <= sel_addr;
               cl_ff   <= cl_ff + 1'b1;
            end else if (pick_r_col) begin
               term_ff <= sel_addr;
               cr_ff   <= cr_ff - 1'b1;
            end else if (cl_ff < cr_ff) begin
               cl_ff <= cl_ff >> 1;
               cr_ff <= cr_ff >> 1;
            end else begin
               inrow_ff <= 1'b0;
            end
         end else if (hl_ff < hr_ff) begin
            if (pick_l_row) begin
               cur_row_ff <= hl_ff[NR-1:0];
               hl_ff      <= hl_ff + 1'b1;
               inrow_ff   <= 1'b1;
               cl_ff      <= wl_ff;
               cr_ff      <= wr_ff;
            end else if (pick_r_row) begin
               cur_row_ff <= NR'(hr_ff - 1'b1);
               hr_ff      <= hr_ff - 1'b1;
               inrow_ff   <= 1'b1;
               cl_ff      <= wl_ff;
               cr_ff      <= wr_ff;
            end else begin
               hl_ff <= hl_ff >> 1;
               hr_ff <= hr_ff >> 1;
            end
         end
      end
      if (cmd.q_acc) acc_ff <= comb_f(mode, acc_ff, rd_ff);
      if (cmd.out_load) result <= 32'(acc_ff);
   end

endmodule

FILE: src/rect_range_reduce_tree.sv
// rect_range_reduce_tree: 2-D reduction tree over a ROWS x COLS grid.
// Requests enter on req_* (valid/stall); results leave on rsp_* from an
// output register. The user must make configuration writes on csr_* only
// while idle; the block itself does not enforce this. Commands: set (no
// result), get (one result), reduce (one result), clear (no result). One
// transaction is worked at a time. Per command: get reads the leaf and
// loads it into the output register; set writes the leaf, then for each
// ancestor node reads both children and writes their combination; reduce
// reads and accumulates each node that the query walk selects; clear
// writes one node per cycle, 4*PR*PC entries with PR and PC the grid
// sizes padded to powers of two. The node memory has one read and one
// write port. Reset: a clearing pass over all 4*PR*PC entries fills the
// memory with zero (the reset identity); req_stall stays high meanwhile.
// A stalled result holds in the output register while the next transaction
// is taken and worked; a get or reduce then waits in its last cycle, with
// req_stall high, until the held result is taken.
module rect_range_reduce_tree #(
   parameter int ROWS        = 16,
   parameter int COLS        = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_row,
   input  logic [3:0]  req_col,
   input  logic [31:0] req_cell_value,
   input  logic [4:0]  req_row_start,
   input  logic [4:0]  req_row_end,
   input  logic [4:0]  req_col_start,
   input  logic [4:0]  req_col_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   rrrt_pkg::cmd_bus_type  cmd;
   rrrt_pkg::sts_bus_type  sts;
   logic [2:0]             mode_ff;
   logic [31:0]            ident_ff;
   logic [VALUE_WIDTH-1:0] ident_x, val_x;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 3'd0;
         ident_ff <= 32'd0;
      end else if (csr_write) begin
         if (csr_index == rrrt_pkg::CSR_MODE) mode_ff <= csr_data[2:0];
         else ident_ff <= csr_data;
      end
   end

   // Sign-extend or truncate to the stored width
   assign ident_x = VALUE_WIDTH'($signed(ident_ff));
   assign val_x   = VALUE_WIDTH'($signed(req_cell_value));

   rrrt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (rrrt_pkg::cmd_type'(req_command)),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   rrrt_dp #(
      .ROWS        (ROWS),
      .COLS        (COLS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .ident         (ident_x),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_val       (val_x),
      .req_row_start (req_row_start),
      .req_row_end   (req_row_end),
      .req_col_start (req_col_start),
      .req_col_end   (req_col_end),
      .cmd           (cmd),
      .sts           (sts),
      .result        (rsp_result_value)
   );

endmodule

FILE: src/rrrt_check.sv
// Port-level checker for rect_range_reduce_tree, bound to the top level.
// Depends only on the top-level ports.
module rrrt_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_value
);

   // A pending result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("result changed while stalled");

   // One transaction at a time: the block is busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction accepted back to back");

   // A presented result is always fully known
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_result_value))
      else $error("result has unknown bits");

endmodule

bind rect_range_reduce_tree rrrt_check u_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value)
);
